// ===== hdl/sha256_stream_hasher_top_assert.svh =====
// Assertion macros for the stream hasher checker.
// The clock and reset must be named i_clk and i_rst_n where these are used.
`ifndef SHA256_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_STREAM_HASHER_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is low.
`define SHS_CHK_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("shs check failed");

// Next-cycle implication, off while reset is low.
`define SHS_CHK_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("shs check failed");

// Next-cycle implication that also runs through reset.
`define SHS_CHK_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("shs reset check failed");

`endif

// ===== hdl/shs_pkg.sv =====
package shs_pkg;

    // Eight 32-bit hash words, element 0 is word a (most significant).
    typedef logic [0:7][31:0] t_words;

    typedef enum logic [1:0] {
        FUNC_ABSORB     = 2'd0,
        FUNC_ABSORB_FIN = 2'd1,
        FUNC_FINISH     = 2'd2,
        FUNC_NONE       = 2'd3
    } t_func;

    localparam t_words H_INIT = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [5:0] LAST_ROUND = 6'd63;

endpackage

// ===== hdl/shs_round.sv =====
module shs_round (
    input  shs_pkg::t_words i_v,
    input  logic [511:0]    i_win,
    input  logic [5:0]      i_round,
    output shs_pkg::t_words o_v,
    output logic [31:0]     o_w
);

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] w0, w1, w9, w14;
    logic [31:0] s0, s1, big_s0, big_s1, ch, maj, t1, t2;

    // window word i sits at bits [511-32i -: 32]
    assign w0  = i_win[511:480];
    assign w1  = i_win[479:448];
    assign w9  = i_win[223:192];
    assign w14 = i_win[63:32];

    assign s0 = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    assign s1 = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    assign o_w = s1 + w9 + s0 + w0;

    assign big_s1 = rotr(i_v[4], 6) ^ rotr(i_v[4], 11) ^ rotr(i_v[4], 25);
    assign big_s0 = rotr(i_v[0], 2) ^ rotr(i_v[0], 13) ^ rotr(i_v[0], 22);
    assign ch     = (i_v[4] & i_v[5]) ^ (~i_v[4] & i_v[6]);
    assign maj    = (i_v[0] & i_v[1]) ^ (i_v[0] & i_v[2]) ^ (i_v[1] & i_v[2]);
    assign t1     = i_v[7] + big_s1 + ch + K_TAB[i_round] + w0;
    assign t2     = big_s0 + maj;

    always_comb begin
        o_v[0] = t1 + t2;
        o_v[1] = i_v[0];
        o_v[2] = i_v[1];
        o_v[3] = i_v[2];
        o_v[4] = i_v[3] + t1;
        o_v[5] = i_v[4];
        o_v[6] = i_v[5];
        o_v[7] = i_v[6];
    end

endmodule

// ===== hdl/sha256_stream_hasher_top.sv =====
// Absorb: one byte per input word; every 64th byte adds a compression (64 rounds + fold).
// Finish: 9 to 72 pad bytes at one per cycle and one or two compressions, then the digest
// loads once the previous digest has left; four output words follow, one per cycle if taken.
// Rate is set by the single shared round unit: one round per cycle.
// Reset (i_rst_n low, synchronous): hash words to the initial values, byte count zero,
// sequencer idle, no output pending. Block buffer contents are not cleared.
module sha256_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_data_byte,
    // output channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_last_word
);

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,  // ready for an input word
        S_COMP = 5'b00010,  // one compression round per cycle
        S_FOLD = 5'b00100,  // add working vars into hash words
        S_PAD  = 5'b01000,  // feed one pad byte per cycle
        S_DONE = 5'b10000   // hand digest to output register
    } t_state;

    // Padding phase
    typedef enum logic [2:0] {
        P_MARK = 3'b001,  // 0x80 byte next
        P_ZERO = 3'b010,  // zeros up to offset 56
        P_LEN  = 3'b100   // bit length, big-endian
    } t_pmode;

    t_state          r_state, n_state;
    t_pmode          r_pmode, n_pmode;
    logic            r_fin, n_fin;
    logic [63:0]     r_cnt, n_cnt;
    logic [63:0]     r_bitlen, n_bitlen;
    // 512-bit block register: bytes shift in at the bottom while absorbing, and
    // during compression it is the 16-word message schedule window.
    logic [511:0]    r_blk, n_blk;
    shs_pkg::t_words r_h, n_h;
    shs_pkg::t_words r_v, n_v;
    logic [5:0]      r_round, n_round;
    // Output register: digest held here so the next message can start.
    shs_pkg::t_words r_dig, n_dig;
    logic            r_ovalid, n_ovalid;
    logic [1:0]      r_oidx, n_oidx;

    shs_pkg::t_words rnd_v;
    logic [31:0]     rnd_w;
    logic [63:0]     cnt_inc;
    logic            a_en;
    logic [7:0]      a_byte;
    logic [7:0]      len_byte;
    logic            in_acc, out_acc;

    shs_round u_round (
        .i_v     (r_v),
        .i_win   (r_blk),
        .i_round (r_round),
        .o_v     (rnd_v),
        .o_w     (rnd_w)
    );

    assign o_ready       = (r_state == S_IDLE);
    assign in_acc        = i_valid && o_ready;
    assign out_acc       = r_ovalid && i_ready;
    assign cnt_inc       = r_cnt + 64'd1;
    // length byte for offsets 56..63: byte j of the big-endian length is bits
    // [63-8j -: 8], and 7-j is the inverse of the low three count bits
    assign len_byte      = r_bitlen[{~r_cnt[2:0], 3'b000} +: 8];

    assign o_valid       = r_ovalid;
    assign o_digest_word = {r_dig[0], r_dig[1]};
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 2'd3);

    always_comb begin
        n_state  = r_state;
        n_pmode  = r_pmode;
        n_fin    = r_fin;
        n_cnt    = r_cnt;
        n_bitlen = r_bitlen;
        n_blk    = r_blk;
        n_h      = r_h;
        n_v      = r_v;
        n_round  = r_round;
        n_dig    = r_dig;
        n_ovalid = r_ovalid;
        n_oidx   = r_oidx;
        a_en     = 1'b0;
        a_byte   = 8'h00;

        // drain digest words, two hash words per output word
        if (out_acc) begin
            n_dig  = r_dig << 64;
            n_oidx = r_oidx + 2'd1;
            if (r_oidx == 2'd3) begin
                n_ovalid = 1'b0;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_func)
                        shs_pkg::FUNC_ABSORB: begin
                            a_en   = 1'b1;
                            a_byte = i_data_byte;
                        end
                        shs_pkg::FUNC_ABSORB_FIN: begin
                            a_en    = 1'b1;
                            a_byte  = i_data_byte;
                            n_fin   = 1'b1;
                            n_pmode = P_MARK;
                        end
                        shs_pkg::FUNC_FINISH: begin
                            n_fin   = 1'b1;
                            n_pmode = P_MARK;
                            n_state = S_PAD;
                        end
                        default: begin
                            // unused code: word taken, nothing done
                        end
                    endcase
                end
            end
            S_PAD: begin
                a_en = 1'b1;
                case (r_pmode)
                    P_MARK: begin
                        a_byte   = shs_pkg::PAD_MARK;
                        n_bitlen = {r_cnt[60:0], 3'b000};
                        n_pmode  = P_ZERO;
                    end
                    P_ZERO: begin
                        if (r_cnt[5:0] == shs_pkg::LEN_OFFSET) begin
                            a_byte  = len_byte;
                            n_pmode = P_LEN;
                        end else begin
                            a_byte = 8'h00;
                        end
                    end
                    P_LEN: begin
                        a_byte = len_byte;
                    end
                    default: begin
                        a_byte = 8'h00;
                    end
                endcase
            end
            S_COMP: begin
                n_v     = rnd_v;
                n_blk   = {r_blk[479:0], rnd_w};
                n_round = r_round + 6'd1;
                if (r_round == shs_pkg::LAST_ROUND) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                for (int i = 0; i < 8; i++) begin
                    n_h[i] = r_h[i] + r_v[i];
                end
                if (!r_fin) begin
                    n_state = S_IDLE;
                end else if (r_pmode == P_LEN) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_DONE: begin
                // wait until the previous digest has fully left
                if (!r_ovalid) begin
                    n_dig    = r_h;
                    n_ovalid = 1'b1;
                    n_oidx   = 2'd0;
                    n_h      = shs_pkg::H_INIT;
                    n_cnt    = 64'd0;
                    n_fin    = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // byte absorb, shared by message and pad bytes
        if (a_en) begin
            n_blk = {r_blk[503:0], a_byte};
            n_cnt = cnt_inc;
            if (cnt_inc[5:0] == 6'd0) begin
                n_state = S_COMP;
                n_v     = r_h;
                n_round = 6'd0;
            end else if (n_fin) begin
                n_state = S_PAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pmode  <= P_MARK;
            r_fin    <= 1'b0;
            r_cnt    <= 64'd0;
            r_h      <= shs_pkg::H_INIT;
            r_round  <= 6'd0;
            r_ovalid <= 1'b0;
            r_oidx   <= 2'd0;
        end else begin
            r_state  <= n_state;
            r_pmode  <= n_pmode;
            r_fin    <= n_fin;
            r_cnt    <= n_cnt;
            r_h      <= n_h;
            r_round  <= n_round;
            r_ovalid <= n_ovalid;
            r_oidx   <= n_oidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bitlen <= n_bitlen;
        r_blk    <= n_blk;
        r_v      <= n_v;
        r_dig    <= n_dig;
    end

endmodule

// ===== hdl/shs_checker.sv =====
`include "sha256_stream_hasher_top_assert.svh"

module shs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [1:0]  i_func,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_digest_word,
    input logic [1:0]  o_word_index,
    input logic        o_last_word
);

    // stalled output word holds
    `SHS_CHK_NXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_digest_word))

    // last flag marks word 3 only
    `SHS_CHK_IMP(a_last_idx, o_valid, o_last_word == (o_word_index == 2'd3))

    // digest words are offered back to back in index order
    `SHS_CHK_NXT(a_idx_seq, o_valid && i_ready && !o_last_word,
                 o_valid && (o_word_index == $past(o_word_index) + 2'd1))

    // a finish request starts padding or a compression, so input is held off
    `SHS_CHK_NXT(a_fin_busy,
                 i_valid && o_ready && (i_func == shs_pkg::FUNC_FINISH ||
                                        i_func == shs_pkg::FUNC_ABSORB_FIN),
                 !o_ready)

    // nothing pending out of reset
    `SHS_CHK_RST(a_rst_idle, !i_rst_n, !o_valid && o_ready)

endmodule

bind sha256_stream_hasher_top shs_checker u_shs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .i_func        (i_func),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_digest_word (o_digest_word),
    .o_word_index  (o_word_index),
    .o_last_word   (o_last_word)
);
